### sv/phbf_pkg.sv
package phbf_pkg;

  // Default parameter values
  localparam int COORD_BITS_DEF    = 24;
  localparam int ROT_FRAC_BITS_DEF = 14;

  // Fixed field widths
  localparam int ROT_ENTRY_BITS = 16;
  localparam int ROW_BITS       = 3 * ROT_ENTRY_BITS;
  localparam int REG_COORD_BITS = 24;
  localparam int RANGE_BITS     = 23;
  localparam int INTENSITY_BITS = 32;
  localparam int CFG_DATA_BITS  = ROW_BITS;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CLASS_BITS     = 2;

  // Register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_ROT_ROW_X  = 3'd0,
    REG_ROT_ROW_Y  = 3'd1,
    REG_ROT_ROW_Z  = 3'd2,
    REG_LIFT_Z     = 3'd3,
    REG_RANGE      = 3'd4,
    REG_FLOOR      = 3'd5,
    REG_CEILING    = 3'd6,
    REG_PLANAR     = 3'd7
  } phbf_reg_e;

  // Evidence classes
  typedef enum logic [CLASS_BITS-1:0] {
    CLS_OUTSIDE = 2'd0,
    CLS_ABOVE   = 2'd1,
    CLS_FREE    = 2'd2,
    CLS_HIT     = 2'd3
  } phbf_class_e;

  // Register reset values
  localparam logic [ROW_BITS-1:0]       ROT_ROW_X_RST = 48'h0000_0000_4000;
  localparam logic [ROW_BITS-1:0]       ROT_ROW_Y_RST = 48'h0000_4000_0000;
  localparam logic [ROW_BITS-1:0]       ROT_ROW_Z_RST = 48'h4000_0000_0000;
  localparam logic [REG_COORD_BITS-1:0] LIFT_Z_RST    = 24'd0;
  localparam logic [RANGE_BITS-1:0]     RANGE_RST     = 23'd10240;
  localparam logic [REG_COORD_BITS-1:0] FLOOR_RST     = 24'd0;
  localparam logic [REG_COORD_BITS-1:0] CEILING_RST   = 24'd2048;

  // Configuration register set
  typedef struct packed {
    logic [ROW_BITS-1:0]              rot_row_x;
    logic [ROW_BITS-1:0]              rot_row_y;
    logic [ROW_BITS-1:0]              rot_row_z;
    logic signed [REG_COORD_BITS-1:0] lift_z;
    logic [RANGE_BITS-1:0]            range_limit;
    logic signed [REG_COORD_BITS-1:0] band_floor;
    logic signed [REG_COORD_BITS-1:0] band_ceiling;
    logic                             planar_only;
  } phbf_cfg_t;

endpackage

### sv/phbf_ifs.sv
// Point input channel
interface phbf_point_if #(
  parameter int COORD_BITS = phbf_pkg::COORD_BITS_DEF
) ();
  logic                                    valid;
  logic                                    ready;
  logic signed [COORD_BITS-1:0]            point_x;
  logic signed [COORD_BITS-1:0]            point_y;
  logic signed [COORD_BITS-1:0]            point_z;
  logic [phbf_pkg::INTENSITY_BITS-1:0]     intensity_bits;

  modport source (output valid, point_x, point_y, point_z, intensity_bits, input ready);
  modport sink   (input valid, point_x, point_y, point_z, intensity_bits, output ready);
endinterface

// Classified point output channel
interface phbf_result_if #(
  parameter int COORD_BITS = phbf_pkg::COORD_BITS_DEF
) ();
  logic                                    valid;
  logic                                    ready;
  logic signed [COORD_BITS-1:0]            out_x;
  logic signed [COORD_BITS-1:0]            out_y;
  logic signed [COORD_BITS-1:0]            out_z;
  logic [phbf_pkg::INTENSITY_BITS-1:0]     out_intensity;
  logic [phbf_pkg::CLASS_BITS-1:0]         evidence_class;
  logic                                    keep;
  logic                                    config_error;

  modport source (output valid, out_x, out_y, out_z, out_intensity, evidence_class, keep,
                  config_error, input ready);
  modport sink   (input valid, out_x, out_y, out_z, out_intensity, evidence_class, keep,
                  config_error, output ready);
endinterface

### sv/point_height_band_filter_unit.sv
// Five register stages lie between an input transfer and its result on the result channel.
// Throughput: one point per cycle; every stage holds one point and stalls only when
// the stage after it is full and stalled, so bubbles are squeezed out.
// The slowest stage is a 16 x COORD_BITS multiply (rotation) or a 23 x 23 square.
// Reset (rst, synchronous): clears all stage valid bits and loads the default
// configuration (identity rotation, 10 m range, 0..2 m band, planar mode on).
module point_height_band_filter_unit #(
  parameter int COORD_BITS    = phbf_pkg::COORD_BITS_DEF,
  parameter int ROT_FRAC_BITS = phbf_pkg::ROT_FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  phbf_point_if.sink                          points,
  phbf_result_if.source                       results,
  input  logic                                cfg_we,
  input  logic [phbf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [phbf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int EW    = phbf_pkg::ROT_ENTRY_BITS;
  localparam int RCB   = phbf_pkg::REG_COORD_BITS;
  localparam int RB    = phbf_pkg::RANGE_BITS;
  localparam int PW    = EW + COORD_BITS;          // one product
  localparam int SUM_W = PW + 2;                   // sum of three products
  localparam int LIFT_W = RCB + ROT_FRAC_BITS;     // scaled lift / band edges
  localparam int ZW    = ((SUM_W > LIFT_W) ? SUM_W : LIFT_W) + 1;
  localparam int RW    = SUM_W + 1 - ROT_FRAC_BITS; // rounded horizontal coordinate
  localparam int AW    = (RW > RB) ? RW : RB;
  localparam int SQ_W  = 2 * RB;
  localparam int PAY_W = 3 * COORD_BITS + phbf_pkg::INTENSITY_BITS;
  localparam logic signed [SUM_W:0] HALF = (SUM_W+1)'(1) <<< (ROT_FRAC_BITS - 1);

  phbf_pkg::phbf_cfg_t cfg;
  logic                cfg_error;

  phbf_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .we        (cfg_we),
    .index     (cfg_index),
    .data      (cfg_data),
    .cfg       (cfg),
    .cfg_error (cfg_error)
  );

  // Stage valid bits and per-stage advance
  logic v1, v2, v3, v4, v5;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  assign rdy5 = !v5 || results.ready;
  assign rdy4 = !v4 || rdy5;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;
  assign points.ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else begin
      if (rdy1) v1 <= points.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) v5 <= v4;
    end
  end

  // Pass-through payload rides along every stage
  logic [PAY_W-1:0] pay1, pay2, pay3, pay4, pay5;

  always_ff @(posedge clk) begin
    if (rdy1) pay1 <= {points.point_x, points.point_y, points.point_z, points.intensity_bits};
    if (rdy2) pay2 <= pay1;
    if (rdy3) pay3 <= pay2;
    if (rdy4) pay4 <= pay3;
    if (rdy5) pay5 <= pay4;
  end

  // Stage 1: nine rotation products
  logic [phbf_pkg::ROW_BITS-1:0]  rows [3];
  logic signed [COORD_BITS-1:0]   crd  [3];
  logic signed [EW-1:0]           ent  [3][3];
  logic signed [PW-1:0]           prod [3][3];

  assign rows[0] = cfg.rot_row_x;
  assign rows[1] = cfg.rot_row_y;
  assign rows[2] = cfg.rot_row_z;
  assign crd[0]  = points.point_x;
  assign crd[1]  = points.point_y;
  assign crd[2]  = points.point_z;

  for (genvar r = 0; r < 3; r++) begin : g_row
    for (genvar c = 0; c < 3; c++) begin : g_col
      assign ent[r][c] = rows[r][c*EW +: EW];
      always_ff @(posedge clk) begin
        if (rdy1) prod[r][c] <= PW'(ent[r][c]) * PW'(crd[c]);
      end
    end
  end

  // Stage 2: row sums, height lifted by the pose
  logic signed [SUM_W-1:0] sx2, sy2;
  logic signed [ZW-1:0]    sz2;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      sx2 <= SUM_W'(prod[0][0]) + SUM_W'(prod[0][1]) + SUM_W'(prod[0][2]);
      sy2 <= SUM_W'(prod[1][0]) + SUM_W'(prod[1][1]) + SUM_W'(prod[1][2]);
      sz2 <= ZW'(prod[2][0]) + ZW'(prod[2][1]) + ZW'(prod[2][2])
           + (ZW'(cfg.lift_z) <<< ROT_FRAC_BITS);
    end
  end

  // Stage 3: round x/y half up, magnitudes, coarse range test, height band test
  logic signed [SUM_W:0]  bx, by, qx, qy;
  logic signed [RW-1:0]   rx, ry;
  logic [RW-1:0]          mx, my;
  logic [AW-1:0]          wx, wy;
  logic signed [ZW-1:0]   ceil_s, floor_s;
  logic [RB-1:0]          ax3, ay3;
  logic                   big3, above3, below3;

  always_comb begin
    bx = (SUM_W+1)'(sx2) + HALF;
    by = (SUM_W+1)'(sy2) + HALF;
    qx = bx >>> ROT_FRAC_BITS;
    qy = by >>> ROT_FRAC_BITS;
    rx = qx[RW-1:0];
    ry = qy[RW-1:0];
    mx = rx[RW-1] ? RW'(-rx) : RW'(rx);
    my = ry[RW-1] ? RW'(-ry) : RW'(ry);
    wx = AW'(mx);
    wy = AW'(my);
    ceil_s  = ZW'(cfg.band_ceiling) <<< ROT_FRAC_BITS;
    floor_s = ZW'(cfg.band_floor) <<< ROT_FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      ax3    <= wx[RB-1:0];
      ay3    <= wy[RB-1:0];
      big3   <= (wx > AW'(cfg.range_limit)) || (wy > AW'(cfg.range_limit));
      above3 <= sz2 > ceil_s;
      below3 <= sz2 < floor_s;
    end
  end

  // Stage 4: squares; operands only matter when within the range limit
  logic [SQ_W-1:0] sqx4, sqy4, sqr4;
  logic            big4, above4, below4;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      sqx4   <= SQ_W'(ax3) * SQ_W'(ax3);
      sqy4   <= SQ_W'(ay3) * SQ_W'(ay3);
      sqr4   <= SQ_W'(cfg.range_limit) * SQ_W'(cfg.range_limit);
      big4   <= big3;
      above4 <= above3;
      below4 <= below3;
    end
  end

  // Stage 5: classify and decide keep
  logic                        far4;
  phbf_pkg::phbf_class_e       cls_next;
  phbf_pkg::phbf_class_e       cls5;
  logic                        keep5, err5;

  always_comb begin
    far4 = big4 || ((SQ_W+1)'(sqx4) + (SQ_W+1)'(sqy4) > (SQ_W+1)'(sqr4));
    if (far4)        cls_next = phbf_pkg::CLS_OUTSIDE;
    else if (above4) cls_next = phbf_pkg::CLS_ABOVE;
    else if (below4) cls_next = phbf_pkg::CLS_FREE;
    else             cls_next = phbf_pkg::CLS_HIT;
  end

  always_ff @(posedge clk) begin
    if (rdy5) begin
      cls5  <= cls_next;
      err5  <= cfg_error;
      keep5 <= !cfg_error && (!cfg.planar_only || cls_next == phbf_pkg::CLS_FREE
                                               || cls_next == phbf_pkg::CLS_HIT);
    end
  end

  // Output register drives the result channel
  assign results.valid          = v5;
  assign results.out_x          = pay5[PAY_W-1 -: COORD_BITS];
  assign results.out_y          = pay5[PAY_W-1-COORD_BITS -: COORD_BITS];
  assign results.out_z          = pay5[phbf_pkg::INTENSITY_BITS +: COORD_BITS];
  assign results.out_intensity  = pay5[phbf_pkg::INTENSITY_BITS-1:0];
  assign results.evidence_class = cls5;
  assign results.keep           = keep5;
  assign results.config_error   = err5;

endmodule

### sv/phbf_cfg_regs.sv
module phbf_cfg_regs (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  we,
  input  logic [phbf_pkg::CFG_INDEX_BITS-1:0]   index,
  input  logic [phbf_pkg::CFG_DATA_BITS-1:0]    data,
  output phbf_pkg::phbf_cfg_t                   cfg,
  output logic                                  cfg_error
);

  phbf_pkg::phbf_cfg_t regs;

  // Register file, truncated to each register's width
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.rot_row_x    <= phbf_pkg::ROT_ROW_X_RST;
      regs.rot_row_y    <= phbf_pkg::ROT_ROW_Y_RST;
      regs.rot_row_z    <= phbf_pkg::ROT_ROW_Z_RST;
      regs.lift_z       <= phbf_pkg::LIFT_Z_RST;
      regs.range_limit  <= phbf_pkg::RANGE_RST;
      regs.band_floor   <= phbf_pkg::FLOOR_RST;
      regs.band_ceiling <= phbf_pkg::CEILING_RST;
      regs.planar_only  <= 1'b1;
    end else if (we) begin
      unique case (phbf_pkg::phbf_reg_e'(index))
        phbf_pkg::REG_ROT_ROW_X: regs.rot_row_x    <= data;
        phbf_pkg::REG_ROT_ROW_Y: regs.rot_row_y    <= data;
        phbf_pkg::REG_ROT_ROW_Z: regs.rot_row_z    <= data;
        phbf_pkg::REG_LIFT_Z:    regs.lift_z       <= data[phbf_pkg::REG_COORD_BITS-1:0];
        phbf_pkg::REG_RANGE:     regs.range_limit  <= data[phbf_pkg::RANGE_BITS-1:0];
        phbf_pkg::REG_FLOOR:     regs.band_floor   <= data[phbf_pkg::REG_COORD_BITS-1:0];
        phbf_pkg::REG_CEILING:   regs.band_ceiling <= data[phbf_pkg::REG_COORD_BITS-1:0];
        phbf_pkg::REG_PLANAR:    regs.planar_only  <= data[0];
        default: ;
      endcase
    end
  end

  assign cfg = regs;

  // Negative floor, floor not below ceiling, or zero range
  assign cfg_error = regs.band_floor[phbf_pkg::REG_COORD_BITS-1]
                  || (regs.band_floor >= regs.band_ceiling)
                  || (regs.range_limit == '0);

endmodule

### sv/phbf_checker.sv
module phbf_checker #(
  parameter int COORD_BITS = phbf_pkg::COORD_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [COORD_BITS-1:0]               out_x,
  input logic [COORD_BITS-1:0]               out_y,
  input logic [COORD_BITS-1:0]               out_z,
  input logic [phbf_pkg::INTENSITY_BITS-1:0] out_intensity,
  input logic [phbf_pkg::CLASS_BITS-1:0]     evidence_class,
  input logic                                keep,
  input logic                                config_error
);

  // A stalled result holds still until transfer
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
      && $stable(out_z) && $stable(out_intensity) && $stable(evidence_class)
      && $stable(keep) && $stable(config_error))
    else $error("result changed while stalled");

  // Invalid configuration never lets a point through
  a_err_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid && config_error |-> !keep)
    else $error("point kept under config error");

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind point_height_band_filter_unit phbf_checker #(.COORD_BITS(COORD_BITS)) u_phbf_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (results.valid),
  .out_ready      (results.ready),
  .out_x          (results.out_x),
  .out_y          (results.out_y),
  .out_z          (results.out_z),
  .out_intensity  (results.out_intensity),
  .evidence_class (results.evidence_class),
  .keep           (results.keep),
  .config_error   (results.config_error)
);
